### hw/rtl/i2r_pkg.sv
// Shared types, codes and constants for the I420 to RGB converter.
package i2r_pkg;

    // Default geometry limits of the frame store
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FLIP_ROWS   = 2'd2;

    // Configuration field widths and reset values
    localparam int CFG_DATA_W = 10;
    localparam int HALF_WIDTH_W  = 10;
    localparam int HALF_HEIGHT_W = 9;
    localparam logic [HALF_WIDTH_W-1:0]  RST_HALF_WIDTH  = 10'd320;
    localparam logic [HALF_HEIGHT_W-1:0] RST_HALF_HEIGHT = 9'd180;
    localparam logic                     RST_FLIP_ROWS   = 1'b1;

    // BT.601 limited-range coefficients (8 fractional bits)
    localparam int PROD_W = 20;
    localparam logic signed [PROD_W-1:0] K_Y        = 20'sd298;
    localparam logic signed [PROD_W-1:0] K_R_CR     = 20'sd409;
    localparam logic signed [PROD_W-1:0] K_G_CB     = 20'sd100;
    localparam logic signed [PROD_W-1:0] K_G_CR     = 20'sd208;
    localparam logic signed [PROD_W-1:0] K_B_CB     = 20'sd516;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 20'sd128;
    localparam logic signed [PROD_W-1:0] LUMA_OFS   = 20'sd16;
    localparam logic signed [PROD_W-1:0] CHROMA_OFS = 20'sd128;

    // Plane being filled during a frame load
    typedef enum logic [1:0] {
        PLANE_Y,
        PLANE_CB,
        PLANE_CR
    } i2r_plane_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } i2r_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic pull_start;
        logic mul_en;
        logic emit;
    } i2r_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_loaded;
    } i2r_status_t;

endpackage

### hw/rtl/i2r_ctrl.sv
// Controller state machine: input and output handshakes, datapath sequencing.
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        command,
    input  logic        out_ready,
    input  i2r_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output i2r_cmd_t    cmd
);

    i2r_state_t state_reg;
    i2r_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       in_beat;

    assign out_free = !out_valid_reg || out_ready;
    assign in_beat  = (state_reg == S_IDLE) && in_valid;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat && command == CMD_PULL)
                begin
                    state_next = status.frame_loaded ? S_MUL : S_EMIT;
                end
            end
            S_MUL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        cmd.load_we    = in_beat && (command == CMD_LOAD);
        cmd.pull_start = in_beat && (command == CMD_PULL);
        cmd.mul_en     = (state_reg == S_MUL);
        cmd.emit       = (state_reg == S_EMIT) && out_free;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/i2r_datapath.sv
// Datapath: configuration, frame store, readout addressing and color conversion.
module i2r_datapath
    import i2r_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            data_byte,
    input  i2r_cmd_t              cmd,
    output i2r_status_t           status,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last_pixel,
    output logic                  not_ready
);

    localparam int HALF_W_MAX   = MAX_WIDTH / 2;
    localparam int HALF_H_MAX   = MAX_HEIGHT / 2;
    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = HALF_W_MAX * HALF_H_MAX;
    localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
    localparam int CHROMA_AW    = (CHROMA_DEPTH > 1) ? $clog2(CHROMA_DEPTH) : 1;
    localparam int HW_W         = $clog2(HALF_W_MAX + 1);
    localparam int HH_W         = $clog2(HALF_H_MAX + 1);
    localparam int CN_W         = $clog2(CHROMA_DEPTH + 1);
    localparam int LN_W         = CN_W + 2;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int PW           = HW_W + HH_W;

    // Saturate floor(v / 256) to 0..255
    function automatic logic [7:0] sat8(input logic signed [PROD_W-1:0] v);
        logic [7:0] res;
        if (v[PROD_W-1])
        begin
            res = 8'd0;
        end
        else if (|v[PROD_W-2:16])
        begin
            res = 8'hFF;
        end
        else
        begin
            res = v[15:8];
        end
        return res;
    endfunction

    // Configuration registers
    logic [HALF_WIDTH_W-1:0]  half_width_reg;
    logic [HALF_HEIGHT_W-1:0] half_height_reg;
    logic                     flip_rows_reg;
    logic                     geometry_write;

    assign geometry_write = cfg_write_en &&
        (cfg_index == REG_HALF_WIDTH || cfg_index == REG_HALF_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= RST_HALF_WIDTH;
            half_height_reg <= RST_HALF_HEIGHT;
            flip_rows_reg   <= RST_FLIP_ROWS;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH:  half_width_reg  <= cfg_data[HALF_WIDTH_W-1:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg_data[HALF_HEIGHT_W-1:0];
                REG_FLIP_ROWS:   flip_rows_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Clamp geometry to the store limits; a zero size counts as one
    logic [HW_W-1:0] hw_eff;
    logic [HH_W-1:0] hh_eff;

    always_comb
    begin
        if (half_width_reg == '0)
        begin
            hw_eff = HW_W'(1);
        end
        else if (32'(half_width_reg) > 32'(HALF_W_MAX))
        begin
            hw_eff = HW_W'(HALF_W_MAX);
        end
        else
        begin
            hw_eff = HW_W'(half_width_reg);
        end
        if (half_height_reg == '0)
        begin
            hh_eff = HH_W'(1);
        end
        else if (32'(half_height_reg) > 32'(HALF_H_MAX))
        begin
            hh_eff = HH_W'(HALF_H_MAX);
        end
        else
        begin
            hh_eff = HH_W'(half_height_reg);
        end
    end

    // Register geometry and plane sizes
    logic [HW_W-1:0] hw_reg;
    logic [HH_W-1:0] hh_reg;
    logic [CN_W-1:0] chroma_n_reg;
    logic [CN_W-1:0] chroma_n_next;
    logic [LN_W-1:0] luma_n;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [LN_W-1:0] w_wide;

    assign chroma_n_next = CN_W'(PW'(hw_reg) * PW'(hh_reg));
    assign luma_n        = {chroma_n_reg, 2'b00};
    assign w_m1          = COL_W'({hw_reg - HW_W'(1), 1'b1});
    assign h_m1          = ROW_W'({hh_reg - HH_W'(1), 1'b1});
    assign w_wide        = LN_W'({hw_reg, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg       <= HW_W'(1);
            hh_reg       <= HH_W'(1);
            chroma_n_reg <= CN_W'(1);
        end
        else
        begin
            hw_reg       <= hw_eff;
            hh_reg       <= hh_eff;
            chroma_n_reg <= chroma_n_next;
        end
    end

    // Load sequencing over the three planes
    i2r_plane_t         plane_reg;
    i2r_plane_t         plane_eff;
    logic [LUMA_AW-1:0] addr_reg;
    logic [LUMA_AW-1:0] addr_eff;
    logic [LN_W-1:0]    addr_inc;
    logic [LN_W-1:0]    plane_size;
    logic               plane_done;
    logic               frame_loaded_reg;
    logic               read_init;
    logic               pull_go;

    assign plane_eff  = frame_loaded_reg ? PLANE_Y : plane_reg;
    assign addr_eff   = frame_loaded_reg ? '0 : addr_reg;
    assign plane_size = (plane_eff == PLANE_Y) ? luma_n : LN_W'(chroma_n_reg);
    assign addr_inc   = LN_W'(addr_eff) + LN_W'(1);
    assign plane_done = (addr_inc == plane_size);
    assign read_init  = cmd.load_we && plane_done && (plane_eff == PLANE_CR);
    assign pull_go    = cmd.pull_start && frame_loaded_reg;

    assign status.frame_loaded = frame_loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg        <= PLANE_Y;
            addr_reg         <= '0;
            frame_loaded_reg <= 1'b0;
        end
        else if (geometry_write)
        begin
            plane_reg        <= PLANE_Y;
            addr_reg         <= '0;
            frame_loaded_reg <= 1'b0;
        end
        else if (cmd.load_we)
        begin
            if (plane_done)
            begin
                addr_reg <= '0;
                unique case (plane_eff)
                    PLANE_Y:
                    begin
                        plane_reg        <= PLANE_CB;
                        frame_loaded_reg <= 1'b0;
                    end
                    PLANE_CB:
                    begin
                        plane_reg        <= PLANE_CR;
                        frame_loaded_reg <= 1'b0;
                    end
                    default:
                    begin
                        plane_reg        <= PLANE_Y;
                        frame_loaded_reg <= 1'b1;
                    end
                endcase
            end
            else
            begin
                plane_reg        <= plane_eff;
                addr_reg         <= LUMA_AW'(addr_inc);
                frame_loaded_reg <= 1'b0;
            end
        end
    end

    // Readout position and row base addresses for both row orders
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [LUMA_AW-1:0]   fwd_luma_reg;
    logic [LUMA_AW-1:0]   rev_luma_reg;
    logic [CHROMA_AW-1:0] fwd_chroma_reg;
    logic [CHROMA_AW-1:0] rev_chroma_reg;
    logic                 row_end;
    logic                 last;
    logic                 read_restart;
    logic [LUMA_AW-1:0]   w_luma;
    logic [CHROMA_AW-1:0] hw_chroma;

    assign row_end      = (col_reg == w_m1);
    assign last         = row_end && (row_reg == h_m1);
    assign read_restart = read_init || (pull_go && last);
    assign w_luma       = LUMA_AW'(w_wide);
    assign hw_chroma    = CHROMA_AW'(hw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            fwd_luma_reg   <= '0;
            rev_luma_reg   <= '0;
            fwd_chroma_reg <= '0;
            rev_chroma_reg <= '0;
        end
        else if (read_restart)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            fwd_luma_reg   <= '0;
            rev_luma_reg   <= LUMA_AW'(luma_n - w_wide);
            fwd_chroma_reg <= '0;
            rev_chroma_reg <= CHROMA_AW'(LN_W'(chroma_n_reg) - LN_W'(hw_reg));
        end
        else if (pull_go)
        begin
            if (row_end)
            begin
                col_reg      <= '0;
                row_reg      <= row_reg + ROW_W'(1);
                fwd_luma_reg <= fwd_luma_reg + w_luma;
                rev_luma_reg <= rev_luma_reg - w_luma;
                // Chroma rows span two luma rows
                if (row_reg[0])
                begin
                    fwd_chroma_reg <= fwd_chroma_reg + hw_chroma;
                    rev_chroma_reg <= rev_chroma_reg - hw_chroma;
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Read addresses of the current pixel
    logic [LUMA_AW-1:0]   luma_rd_addr;
    logic [CHROMA_AW-1:0] chroma_rd_addr;

    assign luma_rd_addr = (flip_rows_reg ? rev_luma_reg : fwd_luma_reg) + LUMA_AW'(col_reg);
    assign chroma_rd_addr = (flip_rows_reg ? rev_chroma_reg : fwd_chroma_reg)
                          + CHROMA_AW'(col_reg >> 1);

    // Frame store
    logic [7:0] luma_mem [LUMA_DEPTH];
    logic [7:0] cb_mem   [CHROMA_DEPTH];
    logic [7:0] cr_mem   [CHROMA_DEPTH];
    logic [7:0] y_rd_reg;
    logic [7:0] cb_rd_reg;
    logic [7:0] cr_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && plane_eff == PLANE_Y)
        begin
            luma_mem[addr_eff] <= data_byte;
        end
        if (pull_go)
        begin
            y_rd_reg <= luma_mem[luma_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && plane_eff == PLANE_CB)
        begin
            cb_mem[addr_eff[CHROMA_AW-1:0]] <= data_byte;
        end
        if (pull_go)
        begin
            cb_rd_reg <= cb_mem[chroma_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && plane_eff == PLANE_CR)
        begin
            cr_mem[addr_eff[CHROMA_AW-1:0]] <= data_byte;
        end
        if (pull_go)
        begin
            cr_rd_reg <= cr_mem[chroma_rd_addr];
        end
    end

    // Capture per-pull flags
    logic nr_reg;
    logic last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pull_start)
        begin
            nr_reg   <= !frame_loaded_reg;
            last_reg <= last;
        end
    end

    // Constant multiplies
    logic signed [PROD_W-1:0] c_val;
    logic signed [PROD_W-1:0] d_val;
    logic signed [PROD_W-1:0] e_val;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic signed [PROD_W-1:0] prod_gb_reg;
    logic signed [PROD_W-1:0] prod_gr_reg;
    logic signed [PROD_W-1:0] prod_b_reg;

    assign c_val = $signed({{(PROD_W-8){1'b0}}, y_rd_reg}) - LUMA_OFS;
    assign d_val = $signed({{(PROD_W-8){1'b0}}, cb_rd_reg}) - CHROMA_OFS;
    assign e_val = $signed({{(PROD_W-8){1'b0}}, cr_rd_reg}) - CHROMA_OFS;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_y_reg  <= c_val * K_Y + ROUND_BIAS;
            prod_r_reg  <= e_val * K_R_CR;
            prod_gb_reg <= d_val * K_G_CB;
            prod_gr_reg <= e_val * K_G_CR;
            prod_b_reg  <= d_val * K_B_CB;
        end
    end

    // Sum, saturate and load the output register
    logic signed [PROD_W-1:0] sum_r;
    logic signed [PROD_W-1:0] sum_g;
    logic signed [PROD_W-1:0] sum_b;
    logic [7:0]               red_reg;
    logic [7:0]               green_reg;
    logic [7:0]               blue_reg;
    logic                     last_pixel_reg;
    logic                     not_ready_reg;

    assign sum_r = prod_y_reg + prod_r_reg;
    assign sum_g = prod_y_reg - prod_gb_reg - prod_gr_reg;
    assign sum_b = prod_y_reg + prod_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (nr_reg)
            begin
                red_reg        <= 8'd0;
                green_reg      <= 8'd0;
                blue_reg       <= 8'd0;
                last_pixel_reg <= 1'b0;
            end
            else
            begin
                red_reg        <= sat8(sum_r);
                green_reg      <= sat8(sum_g);
                blue_reg       <= sat8(sum_b);
                last_pixel_reg <= last_reg;
            end
            not_ready_reg <= nr_reg;
        end
    end

    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign last_pixel = last_pixel_reg;
    assign not_ready  = not_ready_reg;

endmodule

### hw/rtl/i420_frame_to_rgb_converter_top.sv
// Top level of the I420 frame to RGB converter.
//
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready   | command, data_byte
// out     | out | out_valid / out_ready | red, green, blue, last_pixel, not_ready
// cfg     | in  | cfg_write_en          | cfg_index, cfg_data
//
// Loads stream at one byte per clock while no pull is in flight.
// A pull on a loaded frame runs a registered store read, a constant multiply
// stage, then sum and saturate into the output register; an unloaded frame
// skips the multiply. No input beat is taken while a pull is in flight.
// A result waiting in the output register does not block further loads.
// Reset is asynchronous; it clears the load and readout state, not the store.
module i420_frame_to_rgb_converter_top
    import i2r_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last_pixel,
    output logic                  not_ready,
    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    i2r_cmd_t    cmd;
    i2r_status_t status;

    i2r_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    i2r_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .not_ready    (not_ready)
    );

endmodule

### hw/rtl/i2r_checker.sv
// Port-level checker for the converter, bound to the top level.
module i2r_checker
    import i2r_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       last_pixel,
    input logic       not_ready
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(last_pixel) && $stable(not_ready))
        else $error("stalled result beat changed");

    // Drop channels and last flag on a not-ready answer
    a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_ready |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
            && !last_pixel)
        else $error("not-ready result carries pixel data");

    // A pull keeps the input side busy in the next cycle
    a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PULL |=> !in_ready)
        else $error("input taken right after a pull");

    // A load leaves the input side ready in the next cycle
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_LOAD |=> in_ready)
        else $error("input stalled after a load");

endmodule

bind i420_frame_to_rgb_converter_top i2r_checker u_i2r_checker (.*);
